FILE: design/fbb_pkg.sv
`timescale 1ns / 1ps

package fbb_pkg;

    localparam int ACT_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 8;
    localparam int POS_W   = 9;
    localparam int ERR_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUT        = 4'd0;
    localparam logic [ACT_W-1:0] ACT_GET        = 4'd1;
    localparam logic [ACT_W-1:0] ACT_GET_AT     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_FLIP       = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_COMPACT    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_MARK       = 4'd6;
    localparam logic [ACT_W-1:0] ACT_RESET_MARK = 4'd7;
    localparam logic [ACT_W-1:0] ACT_REWIND     = 4'd8;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MODE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd3;

    // register map: word index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [POS_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [ERR_W-1:0] error_code;
        logic [POS_W-1:0] position_now;
        logic [POS_W-1:0] limit_now;
        logic             reading_now;
        logic             has_remaining;
        logic             rd_sel;
    } fbb_res_t;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [POS_W-1:0]  raddr;
    } fbb_mem_req_t;

endpackage

FILE: design/fbb_in_if.sv
`timescale 1ns / 1ps

interface fbb_in_if
    import fbb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_in;
    logic [IDX_W-1:0]  index;

    modport source (output valid, output action, output data_in, output index, input ready);
    modport sink   (input valid, input action, input data_in, input index, output ready);
endinterface

FILE: design/fbb_out_if.sv
`timescale 1ns / 1ps

interface fbb_out_if
    import fbb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic [ERR_W-1:0]  error_code;
    logic [POS_W-1:0]  position_now;
    logic [POS_W-1:0]  limit_now;
    logic              reading_now;
    logic              has_remaining;

    modport source (output valid, output data_out, output error_code, output position_now,
                    output limit_now, output reading_now, output has_remaining, input ready);
    modport sink   (input valid, input data_out, input error_code, input position_now,
                    input limit_now, input reading_now, input has_remaining, output ready);
endinterface

FILE: design/fbb_store.sv
`timescale 1ns / 1ps

module fbb_store
    import fbb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic               clk,
    input  fbb_mem_req_t       req,
    output logic [BYTE_W-1:0]  rdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[AW'(req.waddr)] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[AW'(req.raddr)];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fbb_ctrl.sv
`timescale 1ns / 1ps

module fbb_ctrl
    import fbb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [ACT_W-1:0]  action,
    input  logic [BYTE_W-1:0] data_in,
    input  logic [IDX_W-1:0]  index,
    input  logic [POS_W-1:0]  capacity,
    input  logic [BYTE_W-1:0] rdata,
    output logic              idle,
    output logic              res_load,
    output fbb_res_t          res,
    output fbb_mem_req_t      mem_req
);

    localparam logic [16:0] DEPTH_W = 17'(BUFFER_DEPTH);
    localparam int BOUND_RST = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MOVE = 1'b1;

    logic             state_reg, state_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;
    logic [POS_W-1:0] bound_reg, bound_next;
    logic [POS_W-1:0] mark_reg, mark_next;
    logic             reading_reg, reading_next;

    // compaction sequencer
    logic [POS_W-1:0] base_reg;
    logic [POS_W-1:0] remain_reg;
    logic [POS_W-1:0] rd_cnt_reg;
    logic             wv_reg;
    logic [POS_W-1:0] wa_reg;
    fbb_res_t         pend_reg;

    logic [POS_W-1:0] usable;
    logic [POS_W-1:0] get_lim;
    logic [POS_W-1:0] remain;
    logic [ERR_W-1:0] err;
    logic             rd_sel;
    logic             start_move;
    logic             item_we;
    logic             item_re;
    logic [POS_W-1:0] item_raddr;
    logic             issue;
    logic             finish;
    fbb_res_t         res_item;

    always_comb
    begin
        if (capacity == '0)
            usable = 9'd1;
        else if ({8'b0, capacity} > DEPTH_W)
            usable = 9'(BUFFER_DEPTH);
        else
            usable = capacity;
    end

    assign get_lim = reading_reg ? bound_reg : cursor_reg;
    assign remain  = bound_reg - cursor_reg;

    always_comb
    begin
        cursor_next  = cursor_reg;
        bound_next   = bound_reg;
        mark_next    = mark_reg;
        reading_next = reading_reg;
        err          = ERR_OK;
        rd_sel       = 1'b0;
        start_move   = 1'b0;
        item_we      = 1'b0;
        item_re      = 1'b0;
        item_raddr   = cursor_reg;
        unique case (action)
            ACT_PUT:
            begin
                if (reading_reg)
                    err = ERR_MODE;
                else if (cursor_reg < bound_reg && {8'b0, cursor_reg} < DEPTH_W)
                begin
                    item_we     = 1'b1;
                    cursor_next = cursor_reg + 9'd1;
                end
                else
                    err = ERR_OVER;
            end
            ACT_GET:
            begin
                if (!reading_reg)
                    err = ERR_MODE;
                else if (cursor_reg < bound_reg)
                begin
                    item_re     = 1'b1;
                    rd_sel      = 1'b1;
                    cursor_next = cursor_reg + 9'd1;
                end
                else
                    err = ERR_UNDER;
            end
            ACT_GET_AT:
            begin
                if ({1'b0, index} < get_lim)
                begin
                    item_re    = 1'b1;
                    rd_sel     = 1'b1;
                    item_raddr = {1'b0, index};
                end
                else
                    err = ERR_UNDER;
            end
            ACT_FLIP:
            begin
                mark_next    = '0;
                cursor_next  = '0;
                reading_next = !reading_reg;
                bound_next   = reading_reg ? usable : cursor_reg;
            end
            ACT_CLEAR:
            begin
                bound_next   = usable;
                cursor_next  = '0;
                reading_next = 1'b0;
                mark_next    = '0;
            end
            ACT_COMPACT:
            begin
                mark_next = '0;
                if (reading_reg)
                begin
                    // unread bytes slide to the front, one per cycle
                    if (cursor_reg < bound_reg)
                    begin
                        start_move  = 1'b1;
                        cursor_next = remain;
                    end
                    else
                        cursor_next = '0;
                    bound_next   = usable;
                    reading_next = 1'b0;
                end
                else
                begin
                    bound_next   = cursor_reg;
                    cursor_next  = '0;
                    reading_next = 1'b1;
                end
            end
            ACT_MARK:       mark_next   = cursor_reg;
            ACT_RESET_MARK: cursor_next = mark_reg;
            ACT_REWIND:     cursor_next = '0;
            default:        ;
        endcase
    end

    always_comb
    begin
        res_item.error_code    = err;
        res_item.position_now  = cursor_next;
        res_item.limit_now     = bound_next;
        res_item.reading_now   = reading_next;
        res_item.has_remaining = cursor_next < bound_next;
        res_item.rd_sel        = rd_sel;
    end

    assign issue  = (state_reg == ST_MOVE) && (rd_cnt_reg != remain_reg);
    assign finish = (state_reg == ST_MOVE) && (rd_cnt_reg == remain_reg);

    always_comb
    begin
        state_next = state_reg;
        if (accept && start_move)
            state_next = ST_MOVE;
        else if (finish)
            state_next = ST_IDLE;
    end

    always_comb
    begin
        if (state_reg == ST_MOVE)
        begin
            mem_req.we    = wv_reg;
            mem_req.waddr = wa_reg;
            mem_req.wdata = rdata;
            mem_req.re    = issue;
            mem_req.raddr = base_reg + rd_cnt_reg;
        end
        else
        begin
            mem_req.we    = accept && item_we;
            mem_req.waddr = cursor_reg;
            mem_req.wdata = data_in;
            mem_req.re    = accept && item_re;
            mem_req.raddr = item_raddr;
        end
    end

    assign idle     = (state_reg == ST_IDLE);
    assign res_load = (accept && !start_move) || finish;
    assign res      = (state_reg == ST_MOVE) ? pend_reg : res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            bound_reg   <= 9'(BOUND_RST);
            mark_reg    <= '0;
            reading_reg <= 1'b0;
            rd_cnt_reg  <= '0;
            wv_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wv_reg    <= issue;
            if (accept)
            begin
                cursor_reg  <= cursor_next;
                bound_reg   <= bound_next;
                mark_reg    <= mark_next;
                reading_reg <= reading_next;
                rd_cnt_reg  <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && start_move)
        begin
            base_reg   <= cursor_reg;
            remain_reg <= remain;
            pend_reg   <= res_item;
        end
        if (issue)
        begin
            wa_reg <= rd_cnt_reg;
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == ST_IDLE)
        else $error("word accepted during compaction");

    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE && wv_reg) |-> wa_reg < rd_cnt_reg)
        else $error("compaction write overtakes its read");

    a_move_ends: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> state_reg == ST_IDLE)
        else $error("compaction did not finish");

    a_bound_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        {8'b0, bound_reg} <= DEPTH_W && {8'b0, cursor_reg} <= DEPTH_W)
        else $error("limit or position beyond store");

endmodule

FILE: design/flip_mode_byte_buffer_top.sv
`timescale 1ns / 1ps
// Results: a result word is registered and appears in the cycle after its input
//   word is taken; for compact in reading mode it waits until the copy ends.
// Throughput: one word per cycle while results are taken downstream, for every
//   action except compact in reading mode, which holds the input while the
//   unread bytes are copied through the single store read port.
// Reset: rst_n asynchronous, active low; position, mark and mode clear, limit
//   to 256 (capped at the store depth) and capacity to 256. Store is not cleared.

module flip_mode_byte_buffer_top
    import fbb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // APB-style configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // word channels
    fbb_in_if.sink             in_ch,
    fbb_out_if.source          out_ch
);

    logic [POS_W-1:0]  capacity_reg;
    logic              out_valid_reg;
    fbb_res_t          res_reg;

    logic              accept;
    logic              idle;
    logic              res_load;
    fbb_res_t          res;
    fbb_mem_req_t      mem_req;
    logic [BYTE_W-1:0] rdata;

    // Config register: one word, selected by paddr[2]; other offsets read zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {23'b0, capacity_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        begin
            capacity_reg <= pwdata[POS_W-1:0];
        end
    end

    // The output register decouples the two sides: a new word is taken in the
    // same cycle that the held result is taken downstream.
    assign in_ch.ready = idle && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;

    fbb_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (in_ch.action),
        .data_in  (in_ch.data_in),
        .index    (in_ch.index),
        .capacity (capacity_reg),
        .rdata    (rdata),
        .idle     (idle),
        .res_load (res_load),
        .res      (res),
        .mem_req  (mem_req)
    );

    fbb_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    // Read data sits in the store's output register; it only moves on a new
    // read, which cannot happen while a result is held.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.data_out      = res_reg.rd_sel ? rdata : '0;
    assign out_ch.error_code    = res_reg.error_code;
    assign out_ch.position_now  = res_reg.position_now;
    assign out_ch.limit_now     = res_reg.limit_now;
    assign out_ch.reading_now   = res_reg.reading_now;
    assign out_ch.has_remaining = res_reg.has_remaining;

endmodule

FILE: sim/tb_flip_mode_byte_buffer_top.sv
`timescale 1ns / 1ps

module tb_flip_mode_byte_buffer_top;
    import fbb_pkg::*;

    // status and the spare codes 10..15 leave the buffer untouched
    localparam logic [ACT_W-1:0] ACT_STATUS    = 4'd9;
    localparam logic [ACT_W-1:0] ACT_SPARE_TOP = 4'd15;

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam int STORE_DEPTH = 256;

    // the slowest correct run ends well inside this limit; keep a wide margin
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic [ERR_W-1:0]  error_code;
        logic [POS_W-1:0]  position_now;
        logic [POS_W-1:0]  limit_now;
        logic              reading_now;
        logic              has_remaining;
    } buf_outcome_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    fbb_in_if  in_ch ();
    fbb_out_if out_ch ();

    flip_mode_byte_buffer_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the buffer: store, position, limit, mark, mode and
    // the capacity register as last written. written_map tracks which
    // store entries hold a known byte, so that no read of an unwritten
    // entry is ever issued.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] store_bytes [STORE_DEPTH];
    bit                written_map [STORE_DEPTH];
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  lim;
    logic [POS_W-1:0]  mark_pos;
    logic              rd_mode;
    logic [POS_W-1:0]  cap_reg;

    buf_outcome_t outcome_q [$];

    int  words_sent;
    int  results_checked;
    int  mismatches;
    int  cap_writes;
    int  cycles;
    bit  src_calm;
    bit  sink_calm;
    int  hold_left;
    int  stall_left;

    // Apply one action to the shadow buffer and return the result word
    // it should produce.
    function automatic buf_outcome_t apply_action(input logic [ACT_W-1:0] act,
                                                  input logic [BYTE_W-1:0] din,
                                                  input logic [IDX_W-1:0] idx);
        buf_outcome_t     r;
        logic [POS_W-1:0] cap;
        logic [POS_W-1:0] span;
        int               remain;
        int               k;
        r = '0;
        // register value 0 acts as 1, anything above the depth as the depth
        if (cap_reg == 0)
            cap = 9'd1;
        else if (cap_reg > STORE_DEPTH)
            cap = POS_W'(STORE_DEPTH);
        else
            cap = cap_reg;
        case (act)
            ACT_PUT:
            begin
                if (rd_mode)
                    r.error_code = ERR_MODE;
                else if (pos < lim && pos < STORE_DEPTH)
                begin
                    store_bytes[pos] = din;
                    written_map[pos] = 1'b1;
                    pos = pos + 1'b1;
                end
                else
                    r.error_code = ERR_OVER;
            end
            ACT_GET:
            begin
                if (!rd_mode)
                    r.error_code = ERR_MODE;
                else if (pos < lim)
                begin
                    r.data_out = store_bytes[pos];
                    pos = pos + 1'b1;
                end
                else
                    r.error_code = ERR_UNDER;
            end
            ACT_GET_AT:
            begin
                span = rd_mode ? lim : pos;
                if ({1'b0, idx} < span)
                    r.data_out = store_bytes[idx];
                else
                    r.error_code = ERR_UNDER;
            end
            ACT_FLIP, ACT_COMPACT:
            begin
                if (rd_mode && act == ACT_COMPACT)
                begin
                    // unread bytes slide down to the front, back to writing
                    remain = 0;
                    if (pos < lim)
                        remain = int'(lim) - int'(pos);
                    for (k = 0; k < remain; k++)
                    begin
                        store_bytes[k] = store_bytes[int'(pos) + k];
                        written_map[k] = written_map[int'(pos) + k];
                    end
                    pos = POS_W'(remain);
                    lim = cap;
                    rd_mode = 1'b0;
                end
                else if (rd_mode)
                begin
                    pos = '0;
                    lim = cap;
                    rd_mode = 1'b0;
                end
                else
                begin
                    lim = pos;
                    pos = '0;
                    rd_mode = 1'b1;
                end
                mark_pos = '0;
            end
            ACT_CLEAR:
            begin
                lim = cap;
                pos = '0;
                rd_mode = 1'b0;
                mark_pos = '0;
            end
            ACT_MARK:       mark_pos = pos;
            ACT_RESET_MARK: pos = mark_pos;
            ACT_REWIND:     pos = '0;
            default: ;
        endcase
        r.position_now  = pos;
        r.limit_now     = lim;
        r.reading_now   = rd_mode;
        r.has_remaining = (pos < lim);
        return r;
    endfunction

    // Source gaps: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (src_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word on the input channel and hold it until taken.
    // The expected result is worked out as the word is driven; nothing
    // else can slip in ahead of it, so the order is the same.
    task automatic send_word(input logic [ACT_W-1:0] act,
                             input logic [BYTE_W-1:0] din,
                             input logic [IDX_W-1:0] idx);
        logic [ACT_W-1:0] a;
        logic [POS_W-1:0] span;
        bit               unsafe;
        int               gap;
        int               k;
        a = act;
        unsafe = 1'b0;
        // steer clear of reading store entries that were never written
        if (a == ACT_GET && rd_mode && pos < lim && !written_map[pos])
            unsafe = 1'b1;
        if (a == ACT_GET_AT)
        begin
            span = rd_mode ? lim : pos;
            if ({1'b0, idx} < span && !written_map[idx])
                unsafe = 1'b1;
        end
        if (a == ACT_COMPACT && rd_mode)
            for (k = int'(pos); k < int'(lim) && k < STORE_DEPTH; k++)
                if (!written_map[k])
                    unsafe = 1'b1;
        if (unsafe)
            a = ACT_STATUS;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        outcome_q.push_back(apply_action(a, din, idx));
        in_ch.valid   <= 1'b1;
        in_ch.action  <= a;
        in_ch.data_in <= din;
        in_ch.index   <= idx;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        words_sent++;
    endtask

    // Drop valid and let every outstanding result word come back.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of the capacity register; upper bits carry junk.
    task automatic write_capacity(input logic [POS_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[POS_W-1:0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        cap_reg = word[POS_W-1:0];
        cap_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: every accepted result word is matched, field by field,
    // against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        buf_outcome_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result word with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("data_out", POS_W'(want.data_out), POS_W'(out_ch.data_out));
                check_field("error_code", POS_W'(want.error_code),
                            POS_W'(out_ch.error_code));
                check_field("position_now", want.position_now, out_ch.position_now);
                check_field("limit_now", want.limit_now, out_ch.limit_now);
                check_field("reading_now", POS_W'(want.reading_now),
                            POS_W'(out_ch.reading_now));
                check_field("has_remaining", POS_W'(want.has_remaining),
                            POS_W'(out_ch.has_remaining));
                results_checked++;
            end
        end
    end

    // Receiver: a forced hold-off takes priority, otherwise random stalls,
    // mostly short, now and then long.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (!sink_calm && $urandom_range(0, 99) < 20)
        begin
            out_ch.ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                stall_left = $urandom_range(10, 40) - 1;
            else
                stall_left = $urandom_range(1, 3) - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("flip_mode_byte_buffer_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short walk through every action and the mode, range and mark cases
    // at the reset capacity of 256.
    task automatic test_directed_actions();
        send_word(ACT_GET, 8'h00, 8'h00);         // get while writing: mode error
        send_word(ACT_GET_AT, 8'h00, 8'h00);      // nothing written yet: underflow
        send_word(ACT_PUT, 8'h00, 8'h00);
        send_word(ACT_PUT, 8'hFF, 8'hFF);
        send_word(ACT_MARK, 8'h00, 8'h00);
        send_word(ACT_PUT, 8'hA5, 8'h00);
        send_word(ACT_PUT, 8'h5A, 8'h00);
        send_word(ACT_GET_AT, 8'h00, 8'hFF);      // index past position
        send_word(ACT_GET_AT, 8'h00, 8'h01);
        send_word(ACT_REWIND, 8'h00, 8'h00);
        send_word(ACT_RESET_MARK, 8'h00, 8'h00);
        send_word(ACT_STATUS, 8'hFF, 8'hFF);
        send_word(ACT_SPARE_TOP, 8'hFF, 8'hFF);   // spare code acts as status
        send_word(ACT_FLIP, 8'h00, 8'h00);        // into reading, limit = 2
        send_word(ACT_PUT, 8'h77, 8'h00);         // put while reading: mode error
        send_word(ACT_GET, 8'h00, 8'h00);
        send_word(ACT_COMPACT, 8'h00, 8'h00);     // one unread byte moves to 0
        send_word(ACT_COMPACT, 8'h00, 8'h00);     // compact while writing = flip
        send_word(ACT_GET, 8'h00, 8'h00);
        send_word(ACT_GET, 8'h00, 8'h00);         // at limit: underflow
        send_word(ACT_GET_AT, 8'h00, 8'h01);      // index at limit: underflow
        send_word(ACT_FLIP, 8'h00, 8'h00);        // back to writing
        send_word(ACT_CLEAR, 8'h00, 8'h00);
    endtask

    // Capacity 0 behaves as 1, values above the depth as the depth, and a new value
    // only lands on a clear or on leaving reading mode by flip or compact.
    task automatic test_capacity_extremes();
        wait_idle();
        write_capacity(9'd0);
        send_word(ACT_STATUS, 8'h00, 8'h00);      // limit still the old one
        send_word(ACT_CLEAR, 8'h00, 8'h00);
        send_word(ACT_PUT, 8'h11, 8'h00);
        send_word(ACT_PUT, 8'h22, 8'h00);         // overflow at one byte
        send_word(ACT_FLIP, 8'h00, 8'h00);
        send_word(ACT_GET, 8'h00, 8'h00);
        send_word(ACT_GET, 8'h00, 8'h00);
        send_word(ACT_FLIP, 8'h00, 8'h00);        // reading to writing: limit = 1
        wait_idle();
        write_capacity(9'd300);
        send_word(ACT_CLEAR, 8'h00, 8'h00);
        wait_idle();
        write_capacity(9'd511);
        send_word(ACT_CLEAR, 8'h00, 8'h00);
        send_word(ACT_STATUS, 8'h00, 8'h00);
    endtask

    // Fill the whole store, overflow once, read it all back and underflow.
    task automatic test_full_store();
        int k;
        wait_idle();
        write_capacity(9'd256);
        send_word(ACT_CLEAR, 8'h00, 8'h00);
        for (k = 0; k <= STORE_DEPTH; k++)
            send_word(ACT_PUT, BYTE_W'($urandom), IDX_W'($urandom));
        send_word(ACT_FLIP, 8'h00, 8'h00);
        for (k = 0; k <= STORE_DEPTH; k++)
            send_word(ACT_GET, 8'h00, 8'h00);
        send_word(ACT_COMPACT, 8'h00, 8'h00);     // nothing left to move
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering, so the block backs up and stalls its input.
    task automatic test_backpressure();
        int k;
        src_calm = 1'b1;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        hold_left = 300;
        send_word(ACT_CLEAR, 8'h00, 8'h00);
        for (k = 0; k < 40; k++)
            send_word(ACT_PUT, BYTE_W'($urandom), IDX_W'($urandom));
        send_word(ACT_FLIP, 8'h00, 8'h00);
        for (k = 0; k < 39; k++)
            send_word(ACT_GET, 8'h00, 8'h00);
        send_word(ACT_COMPACT, 8'h00, 8'h00);
        src_calm = 1'b0;
    endtask

    // One random stretch: mostly runs of puts and gets with random data,
    // plus mark / rewind / compact traffic, get_at probes and raw noise.
    task automatic random_traffic(input int count);
        int done;
        int r;
        int room;
        int len;
        int span;
        int k;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 26)
            begin
                if (rd_mode)
                begin
                    send_word($urandom_range(0, 1) ? ACT_FLIP : ACT_COMPACT,
                              BYTE_W'($urandom), IDX_W'($urandom));
                    done++;
                end
                room = int'(lim) - int'(pos);
                if (room < 0)
                    room = 0;
                len = $urandom_range(1, room + 1);
                for (k = 0; k < len; k++)
                    send_word(ACT_PUT, BYTE_W'($urandom), IDX_W'($urandom));
                done += len;
            end
            else if (r < 46)
            begin
                if (!rd_mode)
                begin
                    send_word(ACT_FLIP, BYTE_W'($urandom), IDX_W'($urandom));
                    done++;
                end
                room = int'(lim) - int'(pos);
                if (room < 0)
                    room = 0;
                len = $urandom_range(1, room + 1);
                for (k = 0; k < len; k++)
                    send_word(ACT_GET, BYTE_W'($urandom), IDX_W'($urandom));
                done += len;
            end
            else if (r < 56)
            begin
                span = rd_mode ? int'(lim) : int'(pos);
                if (span > 255)
                    span = 255;
                if ($urandom_range(0, 3) == 0)
                    send_word(ACT_GET_AT, BYTE_W'($urandom),
                              IDX_W'($urandom_range(0, 255)));
                else
                    send_word(ACT_GET_AT, BYTE_W'($urandom),
                              IDX_W'($urandom_range(0, span)));
                done++;
            end
            else
            begin
                if (r < 63)
                    send_word(ACT_COMPACT, BYTE_W'($urandom), IDX_W'($urandom));
                else if (r < 68)
                    send_word(ACT_FLIP, BYTE_W'($urandom), IDX_W'($urandom));
                else if (r < 71)
                    send_word(ACT_CLEAR, BYTE_W'($urandom), IDX_W'($urandom));
                else if (r < 77)
                    send_word(ACT_MARK, BYTE_W'($urandom), IDX_W'($urandom));
                else if (r < 83)
                    send_word(ACT_RESET_MARK, BYTE_W'($urandom), IDX_W'($urandom));
                else if (r < 87)
                    send_word(ACT_REWIND, BYTE_W'($urandom), IDX_W'($urandom));
                else
                    send_word(ACT_W'($urandom_range(0, 15)), BYTE_W'($urandom),
                              IDX_W'($urandom));
                done++;
            end
        end
    endtask

    // Random traffic across a spread of capacity settings, extremes
    // included, with and without idling on either side.
    task automatic test_random_settings();
        logic [POS_W-1:0] caps [8];
        int               p;
        caps[0] = 9'd256;
        caps[1] = 9'd0;
        caps[2] = 9'd1;
        caps[3] = POS_W'($urandom_range(2, 15));
        caps[4] = POS_W'($urandom_range(257, 510));
        caps[5] = 9'd511;
        caps[6] = POS_W'($urandom_range(1, 511));
        caps[7] = POS_W'($urandom_range(16, 64));
        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            write_capacity(caps[p]);
            src_calm  = (p % 3 == 0);
            sink_calm = (p % 4 == 1);
            send_word(ACT_CLEAR, BYTE_W'($urandom), IDX_W'($urandom));
            random_traffic(140);
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        // everything driven to a known value from time zero
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.action  = '0;
        in_ch.data_in = '0;
        in_ch.index   = '0;
        words_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        cap_writes      = 0;
        cycles          = 0;
        src_calm        = 1'b0;
        sink_calm       = 1'b0;
        hold_left       = 0;
        stall_left      = 0;
        // shadow state after reset
        for (k = 0; k < STORE_DEPTH; k++)
        begin
            store_bytes[k] = '0;
            written_map[k] = 1'b0;
        end
        pos      = '0;
        cap_reg  = CAP_RESET;
        lim      = CAP_RESET;
        mark_pos = '0;
        rd_mode  = 1'b0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed_actions();
        test_capacity_extremes();
        test_full_store();
        test_backpressure();
        test_random_settings();

        // drain, then wait on for stray words
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (outcome_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", outcome_q.size());
            mismatches++;
        end

        $display("summary: %0d words sent, %0d result words checked, %0d capacity writes",
                 words_sent, results_checked, cap_writes);
        $display("summary: all actions, mode/overflow/underflow, compact, long hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("flip_mode_byte_buffer_top regression: pass");
        else
            $display("flip_mode_byte_buffer_top regression: fail");
        $finish;
    end

endmodule
